### rtl/hns_pkg.sv
package hns_pkg;

    // Default sizes
    localparam int DEF_MAX_BYTES = 64;
    localparam int DEF_MAX_DIM   = 1024;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_BYTE_COUNT     = 3'd0;
    localparam logic [2:0] REG_ROW_WIDTH      = 3'd1;
    localparam logic [2:0] REG_EXCLUSION_MODE = 3'd2;
    localparam logic [2:0] REG_SKIP_ROW       = 3'd3;
    localparam logic [2:0] REG_SKIP_COL       = 3'd4;

    // Register reset values
    localparam logic [6:0]  RST_BYTE_COUNT = 7'd8;
    localparam logic [10:0] RST_ROW_WIDTH  = 11'd64;

    typedef struct packed {
        logic [6:0]  byte_count;
        logic [10:0] row_width;
        logic        exclusion_mode;
        logic [9:0]  skip_row;
        logic [9:0]  skip_col;
    } cfg_t;

    // Per-chunk facts handed from the chunk unit to the tracker
    typedef struct packed {
        logic       is_query;
        logic       final_chunk;
        logic [6:0] pop;
        logic       data_nz;
        logic       query_nonzero;
    } chunk_info_t;

    typedef struct packed {
        logic       found;
        logic [9:0] row;
        logic [9:0] col;
        logic [9:0] distance;
    } result_t;

    // Count ones in one byte
    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 8; i++) begin
            c = c + {3'd0, v[i]};
        end
        return c;
    endfunction

    // Count ones in a 64-bit word, byte counts summed
    function automatic logic [6:0] pop64(input logic [63:0] v);
        logic [6:0] c;
        c = 7'd0;
        for (int b = 0; b < 8; b++) begin
            c = c + {3'd0, pop8(v[8*b +: 8])};
        end
        return c;
    endfunction

endpackage

### rtl/hns_chunk_unit.sv
module hns_chunk_unit
    import hns_pkg::*;
#(
    parameter int MAX_BYTES = DEF_MAX_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        action,
    input  logic [63:0] data_chunk,
    input  logic [6:0]  byte_count,
    output chunk_info_t info
);

    localparam int QWORDS     = MAX_BYTES / 8;
    localparam int CHUNKS_MAX = (MAX_BYTES + 7) / 8;
    localparam int IW         = (CHUNKS_MAX > 1) ? $clog2(CHUNKS_MAX) : 1;
    localparam int BYW        = $clog2(MAX_BYTES + 1);
    localparam int BW         = (BYW > 7) ? BYW : 7;

    logic [63:0]   query_store [QWORDS];
    logic          query_nonzero_reg;
    logic          query_nonzero_next;
    logic [IW-1:0] chunk_index_reg;
    logic [IW-1:0] chunk_index_next;

    logic [BW-1:0] bytes_raw;
    logic [BW-1:0] bytes_eff;
    logic [BW-1:0] bytes_m1;
    logic [BW-1:0] last_idx;
    logic          final_chunk;
    logic [IW-1:0] idx;
    logic          idx_in_store;
    logic [63:0]   data_masked;
    logic [63:0]   qword;

    // Clamp the byte count and find the last chunk of a bitstring
    always_comb
    begin
        bytes_raw = BW'(byte_count);
        if (byte_count == 7'd0)
        begin
            bytes_eff = BW'(1);
        end
        else if (bytes_raw > BW'(MAX_BYTES))
        begin
            bytes_eff = BW'(MAX_BYTES);
        end
        else
        begin
            bytes_eff = bytes_raw;
        end
        bytes_m1    = bytes_eff - BW'(1);
        last_idx    = bytes_m1 >> 3;
        final_chunk = (BW'(chunk_index_reg) >= last_idx);
        idx         = final_chunk ? last_idx[IW-1:0] : chunk_index_reg;
        idx_in_store = ((IW + 1)'(idx) < (IW + 1)'(QWORDS));
    end

    // Mask tail bytes of the last chunk
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            if (!final_chunk || (3'(k) <= bytes_m1[2:0]))
            begin
                data_masked[8*k +: 8] = data_chunk[8*k +: 8];
            end
            else
            begin
                data_masked[8*k +: 8] = 8'd0;
            end
        end
    end

    // Read the matching query word
    assign qword = idx_in_store ? query_store[idx] : 64'd0;

    always_comb
    begin
        chunk_index_next   = final_chunk ? '0 : idx + IW'(1);
        query_nonzero_next = ((idx != '0) && query_nonzero_reg) || (data_masked != 64'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_index_reg   <= '0;
            query_nonzero_reg <= 1'b0;
        end
        else if (step)
        begin
            chunk_index_reg <= chunk_index_next;
            if (!action)
            begin
                query_nonzero_reg <= query_nonzero_next;
            end
        end
    end

    // Store query chunks; no reset on the store
    always_ff @(posedge clk)
    begin
        if (step && !action && idx_in_store)
        begin
            query_store[idx] <= data_masked;
        end
    end

    always_comb
    begin
        info.is_query      = !action;
        info.final_chunk   = final_chunk;
        info.pop           = pop64(qword ^ data_masked);
        info.data_nz       = (data_masked != 64'd0);
        info.query_nonzero = query_nonzero_reg;
    end

endmodule

### rtl/hns_tracker.sv
module hns_tracker
    import hns_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  chunk_info_t info,
    input  logic        last_candidate,
    input  cfg_t        cfg,
    output logic        emit,
    output result_t     result
);

    localparam int CW  = $clog2(MAX_DIM);
    localparam int CW1 = CW + 1;
    localparam int EW  = (CW1 > 11) ? CW1 : 11;
    localparam int PW  = (CW > 10) ? CW : 10;

    logic [9:0]    running_distance_reg;
    logic [9:0]    running_distance_next;
    logic          candidate_nonzero_reg;
    logic          candidate_nonzero_next;
    logic [CW-1:0] current_row_reg;
    logic [CW-1:0] current_row_next;
    logic [CW-1:0] current_col_reg;
    logic [CW-1:0] current_col_next;
    logic [9:0]    least_distance_reg;
    logic [9:0]    least_distance_next;
    logic [CW-1:0] least_row_reg;
    logic [CW-1:0] least_row_next;
    logic [CW-1:0] least_col_reg;
    logic [CW-1:0] least_col_next;
    logic          have_best_reg;
    logic          have_best_next;

    logic [9:0]    dist_sum;
    logic          skip;
    logic          take;
    logic [EW-1:0] width_raw;
    logic [EW-1:0] width_eff;
    logic [EW-1:0] col_inc;
    logic [CW1-1:0] row_inc;
    logic [PW-1:0] row_ext;
    logic [PW-1:0] col_ext;

    assign emit = !info.is_query && info.final_chunk && last_candidate;

    // Effective row width
    always_comb
    begin
        width_raw = EW'(cfg.row_width);
        if (cfg.row_width == 11'd0)
        begin
            width_eff = EW'(1);
        end
        else if (width_raw > EW'(MAX_DIM))
        begin
            width_eff = EW'(MAX_DIM);
        end
        else
        begin
            width_eff = width_raw;
        end
    end

    // Accumulate, compare and advance position
    always_comb
    begin
        dist_sum = running_distance_reg + {3'd0, info.pop};
        skip = cfg.exclusion_mode &&
               (((PW'(current_row_reg) == PW'(cfg.skip_row)) &&
                 (PW'(current_col_reg) == PW'(cfg.skip_col))) ||
                !(candidate_nonzero_reg || info.data_nz));
        take = !skip && (!have_best_reg || (dist_sum < least_distance_reg));
        col_inc = EW'(current_col_reg) + EW'(1);
        row_inc = CW1'(current_row_reg) + CW1'(1);

        running_distance_next  = dist_sum;
        candidate_nonzero_next = candidate_nonzero_reg || info.data_nz;
        current_row_next       = current_row_reg;
        current_col_next       = current_col_reg;
        least_distance_next    = least_distance_reg;
        least_row_next         = least_row_reg;
        least_col_next         = least_col_reg;
        have_best_next         = have_best_reg;

        if (info.final_chunk)
        begin
            if (take)
            begin
                have_best_next      = 1'b1;
                least_distance_next = dist_sum;
                least_row_next      = current_row_reg;
                least_col_next      = current_col_reg;
            end
            running_distance_next  = 10'd0;
            candidate_nonzero_next = 1'b0;
            if (col_inc >= width_eff)
            begin
                current_col_next = '0;
                if (row_inc >= CW1'(MAX_DIM))
                begin
                    current_row_next = '0;
                end
                else
                begin
                    current_row_next = row_inc[CW-1:0];
                end
            end
            else
            begin
                current_col_next = col_inc[CW-1:0];
            end
        end
    end

    // Form the result from the updated best
    always_comb
    begin
        row_ext         = PW'(least_row_next);
        col_ext         = PW'(least_col_next);
        result.found    = have_best_next && (!cfg.exclusion_mode || info.query_nonzero);
        result.row      = result.found ? row_ext[9:0] : 10'd0;
        result.col      = result.found ? col_ext[9:0] : 10'd0;
        result.distance = result.found ? least_distance_next : 10'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_distance_reg  <= 10'd0;
            candidate_nonzero_reg <= 1'b0;
            current_row_reg       <= '0;
            current_col_reg       <= '0;
            least_distance_reg    <= 10'd0;
            least_row_reg         <= '0;
            least_col_reg         <= '0;
            have_best_reg         <= 1'b0;
        end
        else if (step)
        begin
            // Restart the search on a query chunk or after a result
            if (info.is_query || emit)
            begin
                running_distance_reg  <= 10'd0;
                candidate_nonzero_reg <= 1'b0;
                current_row_reg       <= '0;
                current_col_reg       <= '0;
                least_distance_reg    <= 10'd0;
                least_row_reg         <= '0;
                least_col_reg         <= '0;
                have_best_reg         <= 1'b0;
            end
            else
            begin
                running_distance_reg  <= running_distance_next;
                candidate_nonzero_reg <= candidate_nonzero_next;
                current_row_reg       <= current_row_next;
                current_col_reg       <= current_col_next;
                least_distance_reg    <= least_distance_next;
                least_row_reg         <= least_row_next;
                least_col_reg         <= least_col_next;
                have_best_reg         <= have_best_next;
            end
        end
    end

endmodule

### rtl/hamming_nearest_search_core.sv
// Result path: the final candidate item is taken into the input register, then its
// result into the result register; an older held result can stall it in between.
// Throughput: one item per cycle outside stalls; query word read, popcount, add and
// compare sit in one stage. A final chunk waits only while an older result is held.
// Reset: rst_n clears control and search state and restores default configuration;
// the query store is not reset and must be loaded before use.
module hamming_nearest_search_core
    import hns_pkg::*;
#(
    parameter int MAX_BYTES = DEF_MAX_BYTES,
    parameter int MAX_DIM   = DEF_MAX_DIM
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [63:0] data_chunk,
    input  logic        last_candidate,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [9:0]  best_row,
    output logic [9:0]  best_col,
    output logic [9:0]  best_distance
);

    cfg_t        cfg_reg;
    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [63:0] s1_data_reg;
    logic        s1_last_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    chunk_info_t info;
    result_t     result;
    logic        emit;
    logic        step;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.byte_count     <= RST_BYTE_COUNT;
            cfg_reg.row_width      <= RST_ROW_WIDTH;
            cfg_reg.exclusion_mode <= 1'b0;
            cfg_reg.skip_row       <= 10'd0;
            cfg_reg.skip_col       <= 10'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BYTE_COUNT:     cfg_reg.byte_count     <= cfg_data[6:0];
                REG_ROW_WIDTH:      cfg_reg.row_width      <= cfg_data;
                REG_EXCLUSION_MODE: cfg_reg.exclusion_mode <= cfg_data[0];
                REG_SKIP_ROW:       cfg_reg.skip_row       <= cfg_data[9:0];
                REG_SKIP_COL:       cfg_reg.skip_col       <= cfg_data[9:0];
                default:            ;
            endcase
        end
    end

    // Process the held item unless its result would overrun a waiting one
    assign step     = s1_valid_reg && !(emit && out_valid_reg && !out_ready);
    assign in_ready = !s1_valid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_action_reg <= action;
            s1_data_reg   <= data_chunk;
            s1_last_reg   <= last_candidate;
        end
    end

    hns_chunk_unit #(
        .MAX_BYTES (MAX_BYTES)
    ) u_chunk (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .action     (s1_action_reg),
        .data_chunk (s1_data_reg),
        .byte_count (cfg_reg.byte_count),
        .info       (info)
    );

    hns_tracker #(
        .MAX_DIM (MAX_DIM)
    ) u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .info           (info),
        .last_candidate (s1_last_reg),
        .cfg            (cfg_reg),
        .emit           (emit),
        .result         (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = out_reg.found;
    assign best_row      = out_reg.row;
    assign best_col      = out_reg.col;
    assign best_distance = out_reg.distance;

    // A held result is never overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && emit && out_valid_reg && !out_ready))
        else $error("result register overwritten while held");

    // Stall only comes from a held final item blocked by a held result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && emit && out_valid_reg))
        else $error("input stalled without a blocked result");

    // An empty result carries zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.found) |->
            (out_reg.row == 10'd0 && out_reg.col == 10'd0 && out_reg.distance == 10'd0))
        else $error("result not found but fields nonzero");

    // A new result follows the processing of a final candidate chunk
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step && !info.is_query && info.final_chunk))
        else $error("result without a final candidate chunk");

endmodule
